### rtl/hrlp_pkg.sv
package hrlp_pkg;

    localparam int HUE_W      = 9;
    localparam int LEVEL_W    = 7;
    localparam int PULSE_W    = 19;
    localparam int RAMP_W     = 8;
    localparam int OFFSET_W   = 6;

    localparam int unsigned PERIOD_NS_DEF = 1000000;
    localparam int unsigned HUE_MOD       = 360;
    localparam int unsigned HUE_STEP_RST  = 2;
    localparam int unsigned FULL_SCALE    = 255;
    localparam int unsigned LEVEL_DEPTH   = 2 ** LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(FULL_SCALE / 3);
    localparam logic [PULSE_W-1:0] PULSE_SAT  = {PULSE_W{1'b1}};

    // One region for each 60-degree sector of the color wheel.
    typedef enum logic [2:0] {
        RGN_RED_YELLOW,
        RGN_YELLOW_GREEN,
        RGN_GREEN_CYAN,
        RGN_CYAN_BLUE,
        RGN_BLUE_MAGENTA,
        RGN_MAGENTA_RED
    } region_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_level_t;

    // Floor of x / 3 for an 8-bit x, as a multiply by 171 / 512.
    function automatic logic [LEVEL_W-1:0] div3(input logic [RAMP_W-1:0] x);
        logic [RAMP_W+RAMP_W-1:0] prod;
        prod = x * RAMP_W'(171);
        return prod[RAMP_W+RAMP_W-1 -: LEVEL_W];
    endfunction

    // Pulse width for one level, saturated to the port width. Only ever
    // evaluated on constants while the lookup table is built.
    function automatic logic [PULSE_W-1:0] pulse_calc(input int unsigned level,
                                                      input longint unsigned period);
        longint unsigned width;
        width = (period * longint'(level)) / 64'd255;
        if (width > longint'(PULSE_SAT))
            return PULSE_SAT;
        return PULSE_W'(width);
    endfunction

endpackage

### rtl/hrlp_wheel.sv
module hrlp_wheel (
    input  logic [hrlp_pkg::HUE_W-1:0] hue,
    output hrlp_pkg::rgb_level_t       level
);
    import hrlp_pkg::*;

    region_t             region;
    logic [HUE_W-1:0]    base;
    logic [HUE_W-1:0]    offset_full;
    logic [OFFSET_W-1:0] offset;
    logic [RAMP_W+1:0]   ramp_x17;
    logic [RAMP_W-1:0]   up;
    logic [RAMP_W-1:0]   down;
    logic [LEVEL_W-1:0]  up_lvl;
    logic [LEVEL_W-1:0]  down_lvl;

    always_comb
    begin
        priority if (hue >= HUE_W'(300))
        begin
            region = RGN_MAGENTA_RED;
            base   = HUE_W'(300);
        end
        else if (hue >= HUE_W'(240))
        begin
            region = RGN_BLUE_MAGENTA;
            base   = HUE_W'(240);
        end
        else if (hue >= HUE_W'(180))
        begin
            region = RGN_CYAN_BLUE;
            base   = HUE_W'(180);
        end
        else if (hue >= HUE_W'(120))
        begin
            region = RGN_GREEN_CYAN;
            base   = HUE_W'(120);
        end
        else if (hue >= HUE_W'(60))
        begin
            region = RGN_YELLOW_GREEN;
            base   = HUE_W'(60);
        end
        else
        begin
            region = RGN_RED_YELLOW;
            base   = '0;
        end
    end

    // The ramp 255 * m / 60 is exactly 17 * m / 4.
    assign offset_full = hue - base;
    assign offset      = offset_full[OFFSET_W-1:0];
    assign ramp_x17    = {offset, 4'b0000} + (RAMP_W+2)'(offset);
    assign up          = ramp_x17[RAMP_W+1:2];
    assign down        = RAMP_W'(FULL_SCALE) - up;
    assign up_lvl      = div3(up);
    assign down_lvl    = div3(down);

    always_comb
    begin
        unique case (region)
            RGN_RED_YELLOW:   level = '{red: LEVEL_FULL, green: up_lvl,     blue: '0};
            RGN_YELLOW_GREEN: level = '{red: down_lvl,   green: LEVEL_FULL, blue: '0};
            RGN_GREEN_CYAN:   level = '{red: '0,         green: LEVEL_FULL, blue: up_lvl};
            RGN_CYAN_BLUE:    level = '{red: '0,         green: down_lvl,   blue: LEVEL_FULL};
            RGN_BLUE_MAGENTA: level = '{red: up_lvl,     green: '0,         blue: LEVEL_FULL};
            RGN_MAGENTA_RED:  level = '{red: LEVEL_FULL, green: '0,         blue: down_lvl};
            default:          level = '0;
        endcase
    end

endmodule

### rtl/hsv_rainbow_led_pulse_generator.sv
// Channel   Signals                                 Direction  Carries
// in        in_valid, in_ready, enable              input      one animation tick
// out       out_valid, out_ready, hue_shown, levels,
//           pulses                                  output     color of that tick
// cfg       cfg_valid, cfg_ready, hue_step          input      hue step register write
//
// Ticks go one per cycle, unless the output stalls, via s1 to the output registers.
// The hue advances in the cycle of acceptance, so back-to-back ticks see it.
// A stalled output holds its result; the input register still takes one more.
// Reset clears the hue to 0 and loads a step of 2 degrees.
// The configuration port is always ready.
module hsv_rainbow_led_pulse_generator #(
    parameter longint unsigned PERIOD_NS = hrlp_pkg::PERIOD_NS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          enable,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hrlp_pkg::HUE_W-1:0]    hue_shown,
    output logic [hrlp_pkg::LEVEL_W-1:0]  red_level,
    output logic [hrlp_pkg::LEVEL_W-1:0]  green_level,
    output logic [hrlp_pkg::LEVEL_W-1:0]  blue_level,
    output logic [hrlp_pkg::PULSE_W-1:0]  red_pulse,
    output logic [hrlp_pkg::PULSE_W-1:0]  green_pulse,
    output logic [hrlp_pkg::PULSE_W-1:0]  blue_pulse,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hrlp_pkg::HUE_W-1:0]    hue_step
);
    import hrlp_pkg::*;

    logic [HUE_W-1:0]   hue_step_reg;
    logic [HUE_W-1:0]   hue_angle_reg;
    logic [HUE_W-1:0]   hue_angle_next;
    logic [HUE_W:0]     hue_sum;

    logic               s1_valid_reg;
    logic               s1_en_reg;
    logic [HUE_W-1:0]   s1_hue_reg;

    logic               out_valid_reg;
    logic [HUE_W-1:0]   hue_shown_reg;
    rgb_level_t         level_reg;
    rgb_level_t         level_next;
    rgb_level_t         wheel_level;
    logic [PULSE_W-1:0] red_pulse_reg;
    logic [PULSE_W-1:0] green_pulse_reg;
    logic [PULSE_W-1:0] blue_pulse_reg;

    logic               in_accept;
    logic               s2_load;

    logic [PULSE_W-1:0] pulse_lut [LEVEL_DEPTH];

    for (genvar i = 0; i < LEVEL_DEPTH; i++)
    begin : g_pulse_lut
        assign pulse_lut[i] = pulse_calc(i, PERIOD_NS);
    end

    assign s2_load   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s2_load;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // The sum stays below 871, so at most two subtractions bring it into range.
    assign hue_sum = {1'b0, hue_angle_reg} + {1'b0, hue_step_reg};

    always_comb
    begin
        priority if (hue_sum >= (HUE_W+1)'(2 * HUE_MOD))
            hue_angle_next = HUE_W'(hue_sum - (HUE_W+1)'(2 * HUE_MOD));
        else if (hue_sum >= (HUE_W+1)'(HUE_MOD))
            hue_angle_next = HUE_W'(hue_sum - (HUE_W+1)'(HUE_MOD));
        else
            hue_angle_next = hue_sum[HUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_step_reg  <= HUE_W'(HUE_STEP_RST);
            hue_angle_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hue_step_reg <= hue_step;
            if (in_accept && enable)
                hue_angle_reg <= hue_angle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_en_reg  <= enable;
            s1_hue_reg <= hue_angle_reg;
        end
    end

    hrlp_wheel u_wheel (
        .hue   (s1_hue_reg),
        .level (wheel_level)
    );

    assign level_next = s1_en_reg ? wheel_level : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            hue_shown_reg   <= s1_en_reg ? s1_hue_reg : '0;
            level_reg       <= level_next;
            red_pulse_reg   <= pulse_lut[level_next.red];
            green_pulse_reg <= pulse_lut[level_next.green];
            blue_pulse_reg  <= pulse_lut[level_next.blue];
        end
    end

    assign out_valid   = out_valid_reg;
    assign hue_shown   = hue_shown_reg;
    assign red_level   = level_reg.red;
    assign green_level = level_reg.green;
    assign blue_level  = level_reg.blue;
    assign red_pulse   = red_pulse_reg;
    assign green_pulse = green_pulse_reg;
    assign blue_pulse  = blue_pulse_reg;

    a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hue_angle_reg < HUE_W'(HUE_MOD))
        else $error("hue angle left the 0..359 range");

    a_hue_holds_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !enable |=> $stable(hue_angle_reg))
        else $error("hue moved on a disabled tick");

    a_hue_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && enable && !(cfg_valid && cfg_ready)
        |=> (hue_angle_reg == $past(hue_angle_next)))
        else $error("hue did not advance by the step");

    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg.red <= LEVEL_FULL) && (level_reg.green <= LEVEL_FULL)
                          && (level_reg.blue <= LEVEL_FULL))
        else $error("color level above full scale");

    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load && !s1_en_reg |=> (level_reg == '0) && (hue_shown_reg == '0))
        else $error("disabled tick produced light");

endmodule

### sim/hrlp_tick_checker.sv
`timescale 1ns / 1ps

module hrlp_tick_checker #(
    parameter longint unsigned PERIOD_NS = hrlp_pkg::PERIOD_NS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         enable,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [hrlp_pkg::HUE_W-1:0]   hue_shown,
    input  logic [hrlp_pkg::LEVEL_W-1:0] red_level,
    input  logic [hrlp_pkg::LEVEL_W-1:0] green_level,
    input  logic [hrlp_pkg::LEVEL_W-1:0] blue_level,
    input  logic [hrlp_pkg::PULSE_W-1:0] red_pulse,
    input  logic [hrlp_pkg::PULSE_W-1:0] green_pulse,
    input  logic [hrlp_pkg::PULSE_W-1:0] blue_pulse,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [hrlp_pkg::HUE_W-1:0]   hue_step,
    output int                           mismatches,
    output int                           outstanding
);
    import hrlp_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        rgb_level_t         level;
        logic [PULSE_W-1:0] red_pulse;
        logic [PULSE_W-1:0] green_pulse;
        logic [PULSE_W-1:0] blue_pulse;
    } tick_color_t;

    tick_color_t      color_q[$];
    logic [HUE_W-1:0] hue_angle;
    logic [HUE_W-1:0] step_deg;

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic logic [PULSE_W-1:0] pulse_width(input logic [LEVEL_W-1:0] lvl);
        longint unsigned w;
        w = (PERIOD_NS * 64'(lvl)) / 64'd255;
        if (w > 64'(PULSE_SAT))
            return PULSE_SAT;
        return PULSE_W'(w);
    endfunction

    // Full-saturation wheel color for one hue, dimmed to a third.
    function automatic tick_color_t wheel_color(input logic [HUE_W-1:0] h);
        tick_color_t c;
        region_t     rgn;
        int unsigned hv, up, down, r, g, b;
        hv   = h;
        rgn  = region_t'(hv / 60);
        up   = (hv % 60) * 255 / 60;
        down = 255 - up;
        case (rgn)
            RGN_RED_YELLOW:   begin r = 255;  g = up;   b = 0;    end
            RGN_YELLOW_GREEN: begin r = down; g = 255;  b = 0;    end
            RGN_GREEN_CYAN:   begin r = 0;    g = 255;  b = up;   end
            RGN_CYAN_BLUE:    begin r = 0;    g = down; b = 255;  end
            RGN_BLUE_MAGENTA: begin r = up;   g = 0;    b = 255;  end
            default:          begin r = 255;  g = 0;    b = down; end
        endcase
        c.hue         = h;
        c.level.red   = LEVEL_W'(r / 3);
        c.level.green = LEVEL_W'(g / 3);
        c.level.blue  = LEVEL_W'(b / 3);
        c.red_pulse   = pulse_width(c.level.red);
        c.green_pulse = pulse_width(c.level.green);
        c.blue_pulse  = pulse_width(c.level.blue);
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_color_t want;
        int unsigned sum;
        if (!rst_n)
        begin
            hue_angle = '0;
            step_deg  = HUE_STEP_RST;
            color_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_deg = hue_step;

            if (out_valid && out_ready)
            begin
                if (color_q.size() == 0)
                begin
                    $error("result transaction with no tick outstanding");
                    mismatches++;
                end
                else
                begin
                    want = color_q.pop_front();
                    check_field("hue_shown", want.hue, hue_shown);
                    check_field("red_level", want.level.red, red_level);
                    check_field("green_level", want.level.green, green_level);
                    check_field("blue_level", want.level.blue, blue_level);
                    check_field("red_pulse", want.red_pulse, red_pulse);
                    check_field("green_pulse", want.green_pulse, green_pulse);
                    check_field("blue_pulse", want.blue_pulse, blue_pulse);
                end
            end

            if (in_valid && in_ready)
            begin
                // A disabled tick shows all zeros and leaves the hue alone.
                if (enable)
                begin
                    want      = wheel_color(hue_angle);
                    sum       = int'(hue_angle) + int'(step_deg);
                    hue_angle = HUE_W'(sum % HUE_MOD);
                end
                else
                    want = '0;
                color_q.push_back(want);
            end

            outstanding <= color_q.size();
        end
    end

endmodule

### sim/tb_hsv_rainbow_led_pulse_generator.sv
`timescale 1ns / 1ps

module tb_hsv_rainbow_led_pulse_generator;
    import hrlp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 200;
    localparam int PIPE_LATENCY = 4;
    localparam int TICK_TARGET  = 1500;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               enable = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [HUE_W-1:0]   hue_shown;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [PULSE_W-1:0] red_pulse;
    logic [PULSE_W-1:0] green_pulse;
    logic [PULSE_W-1:0] blue_pulse;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [HUE_W-1:0]   hue_step = '0;

    int mismatches;
    int outstanding;
    int ticks_sent = 0;
    int idle_cycles = 0;

    always #1 clk = ~clk;

    hsv_rainbow_led_pulse_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .enable      (enable),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hue_shown   (hue_shown),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .red_pulse   (red_pulse),
        .green_pulse (green_pulse),
        .blue_pulse  (blue_pulse),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .hue_step    (hue_step)
    );

    hrlp_tick_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .enable      (enable),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hue_shown   (hue_shown),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .red_pulse   (red_pulse),
        .green_pulse (green_pulse),
        .blue_pulse  (blue_pulse),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .hue_step    (hue_step),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(input logic en, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        enable   <= en;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // The step is only changed once every tick in flight has come out.
    task automatic write_step(input logic [HUE_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        hue_step  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int unsigned disable_pct);
        bit dense;
        int k;
        dense = ($urandom_range(0, 3) == 0);
        for (k = 0; k < count; k++)
            send_tick($urandom_range(0, 99) >= disable_pct, dense ? 0 : pick_gap());
    endtask

    // Receiver: random back-pressure, one long hold during the hue sweep while
    // ticks keep coming, and another every few hundred rounds, so the
    // pipeline fills and the input stalls.
    initial
    begin
        int round;
        bit held_long;
        round = 0;
        held_long = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            round++;
            if (round % 250 == 0 || (!held_long && ticks_sent >= 100))
            begin
                held_long = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [HUE_W-1:0] step_pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step of 2, then disabled ticks that must hold the hue.
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 1);
        send_tick(1'b0, 0);
        send_tick(1'b0, 2);
        send_tick(1'b1, 0);

        // A step of 359 walks the hue backward.
        write_step(9'd359);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);

        // Steps above 359 still wrap modulo 360.
        write_step(9'd511);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        write_step(9'd360);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);

        write_step(9'd0);
        send_tick(1'b1, 0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);

        // A step of one sweeps every hue, so every region boundary is seen.
        write_step(9'd1);
        run_phase(420, 5);

        while (ticks_sent < TICK_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       step_pick = 9'd0;
                1:       step_pick = 9'd359;
                2:       step_pick = 9'd511;
                3:       step_pick = 9'd360;
                default: step_pick = HUE_W'($urandom_range(0, 511));
            endcase
            write_step(step_pick);
            run_phase($urandom_range(20, 150), $urandom_range(0, 30));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY * 2) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
